/* design/bit_vector_with_range_erase_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the packed bit array with range erase
// Clocked implication checks with reset masking, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_WITH_RANGE_ERASE_ASSERT_SVH
`define BIT_VECTOR_WITH_RANGE_ERASE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BVRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BVRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bvre_pkg.sv */
// ----------------------------------------------------------------------------
// bvre_pkg
// Shared types, codes and helpers for the packed bit array with range erase.
// ----------------------------------------------------------------------------
package bvre_pkg;

  localparam int LEN_W   = 11;  // length in bits, 0..1024
  localparam int IDX_W   = 10;  // bit index
  localparam int BP_W    = 10;  // byte positions, incl. source look-ahead
  localparam int Q_DEPTH = 2;   // command queue depth, power of two

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_READ   = 3'd1,
    OP_FILL   = 3'd2,
    OP_ERASE  = 3'd3,
    OP_RESIZE = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // work handed from the front end to the byte sequencer
  typedef enum logic [2:0] {
    CK_NONE,
    CK_SET,
    CK_READ,
    CK_FILL,
    CK_ERASE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SET,
    BK_READ,
    BK_FILL,
    BK_ER_ORIG,
    BK_ER_LO,
    BK_ER_RUN,
    BK_RESP
  } bk_state_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [IDX_W-1:0] bit_index;
    logic             bit_value;
    logic [LEN_W-1:0] erase_count;
    logic [LEN_W-1:0] new_length;
  } in_item_t;

  typedef struct packed {
    logic             read_bit;
    logic [1:0]       status;
    logic [LEN_W-1:0] current_length;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [BP_W-1:0]  byte_lo;      // first byte touched
    logic [BP_W-1:0]  byte_end;     // one past the last byte written
    logic [BP_W-1:0]  shift_bytes;  // erase distance, whole bytes
    logic [2:0]       shift_bits;   // erase distance, bits within a byte
    logic [2:0]       bit_sel;
    logic             bit_value;
    logic [1:0]       status;
    logic [LEN_W-1:0] len_after;
  } cmd_t;

  // bytes covered by a length in bits, rounded up
  function automatic logic [BP_W-1:0] active_bytes(input logic [LEN_W-1:0] len);
    logic [LEN_W:0] t;
    t = {1'b0, len} + (LEN_W+1)'(7);
    return BP_W'(t >> 3);
  endfunction

endpackage

/* design/bit_vector_with_range_erase.sv */
// ----------------------------------------------------------------------------
// bit_vector_with_range_erase
// Packed bit array with length: set, read, fill, range erase and resize.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_item_t  (one operation)
//   out_     output     out_valid / out_stall  out_item_t (one result each)
//
// The sequencer walks the byte store one byte per cycle; items with no
//   memory work only post a result. Set reads and rewrites one byte, read
//   reads one, fill and growing resize write each active or gained byte,
//   and erase rewrites each byte from the first erased byte to the new end.
// The front end takes an item a cycle while the two-entry queue has room.
// Synchronous reset clears length, queue and sequencer; bytes are cleared
// as they become active, so there is no clearing pass.
// A stalled result leaves the queue filling and the front end stalls.
// ----------------------------------------------------------------------------
module bit_vector_with_range_erase #(
  parameter int MAX_BITS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bvre_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bvre_pkg::out_item_t out_data
);
  import bvre_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  bvre_front #(.MAX_BITS(MAX_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  bvre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (head_cmd)
  );

  bvre_back #(.MAX_BITS(MAX_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* design/bvre_front.sv */
// ----------------------------------------------------------------------------
// bvre_front
// Accepts items, tracks the array length and turns each item into a byte
// command with its result status and length already settled.
// ----------------------------------------------------------------------------
module bvre_front #(
  parameter int MAX_BITS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bvre_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output bvre_pkg::cmd_t     q_cmd
);
  import bvre_pkg::*;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [BP_W-1:0]  act;
  logic [BP_W-1:0]  idx_byte;
  logic [LEN_W-1:0] room, er_cnt, er_len;
  logic [BP_W-1:0]  er_act;
  logic             er_live;
  logic             rs_sat;
  logic [LEN_W-1:0] rs_len;
  logic [BP_W-1:0]  rs_act;
  cmd_t             cmd;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_cmd    = cmd;

  assign act      = active_bytes(len_r);
  assign idx_byte = BP_W'(in_data.bit_index >> 3);

  // erase: clamp the run to the end of the array
  assign room    = len_r - LEN_W'(in_data.bit_index);
  assign er_cnt  = (in_data.erase_count > room) ? room : in_data.erase_count;
  assign er_len  = len_r - er_cnt;
  assign er_act  = active_bytes(er_len);
  assign er_live = ({1'b0, in_data.bit_index} < len_r) && (er_cnt != '0);

  assign rs_sat = int'(in_data.new_length) > MAX_BITS;
  assign rs_len = rs_sat ? LEN_W'(MAX_BITS) : in_data.new_length;
  assign rs_act = active_bytes(rs_len);

  always_comb begin
    cmd             = '0;
    cmd.kind        = CK_NONE;
    cmd.status      = ST_OK;
    cmd.bit_sel     = in_data.bit_index[2:0];
    cmd.bit_value   = in_data.bit_value;
    len_nxt         = len_r;
    case (in_data.opcode)
      OP_SET: begin
        cmd.byte_lo = idx_byte;
        if (idx_byte < act) cmd.kind = CK_SET;
        else cmd.status = ST_INDEX;
      end
      OP_READ: begin
        cmd.byte_lo = idx_byte;
        if (idx_byte < act) cmd.kind = CK_READ;
        else cmd.status = ST_INDEX;
      end
      OP_FILL: begin
        cmd.byte_lo  = '0;
        cmd.byte_end = act;
        if (act != '0) cmd.kind = CK_FILL;
      end
      OP_ERASE: begin
        cmd.byte_lo     = idx_byte;
        cmd.byte_end    = er_act;
        cmd.shift_bytes = BP_W'(er_cnt >> 3);
        cmd.shift_bits  = er_cnt[2:0];
        if (er_live) begin
          len_nxt = er_len;
          // a run that starts on a byte boundary and reaches the array end leaves nothing to rewrite
          if (idx_byte < er_act) cmd.kind = CK_ERASE;
        end
      end
      OP_RESIZE: begin
        len_nxt       = rs_len;
        cmd.byte_lo   = act;
        cmd.byte_end  = rs_act;
        cmd.bit_value = 1'b0;
        if (rs_sat) cmd.status = ST_SAT;
        // bytes gained are cleared; on shrink the dropped bytes simply go dead
        if (rs_act > act) cmd.kind = CK_FILL;
      end
      default: ;
    endcase
    cmd.len_after = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (q_push) begin
      len_r <= len_nxt;
    end
  end

endmodule

/* design/bvre_queue.sv */
// ----------------------------------------------------------------------------
// bvre_queue
// Short command queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module bvre_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bvre_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output bvre_pkg::cmd_t pop_cmd
);
  import bvre_pkg::*;

  localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  cmd_t            ent_r [Q_DEPTH];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PtrW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (PtrW+1)'(Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + PtrW'(1) : wr_r;
    rd_nxt  = pop  ? rd_r + PtrW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (PtrW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (PtrW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_cmd;
  end

endmodule

/* design/bvre_back.sv */
// ----------------------------------------------------------------------------
// bvre_back
// Byte sequencer: owns the byte store and carries out set, read, fill/clear
// sweeps and the erase slide, then posts the result to the output register.
// ----------------------------------------------------------------------------
module bvre_back #(
  parameter int MAX_BITS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  bvre_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bvre_pkg::out_item_t out_data
);
  import bvre_pkg::*;

  localparam int StoreBytes = (MAX_BITS + 7) / 8;
  localparam int AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;

  logic [7:0]       mem [StoreBytes];
  logic [7:0]       rd_data_r;
  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [7:0]       wr_data;

  bk_state_t        state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [BP_W-1:0]  k_r, k_nxt, src_r, src_nxt;
  logic [7:0]       lo_r, lo_nxt, orig_r, orig_nxt;
  logic             rbit_r, rbit_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             out_free;
  logic             load_out;
  logic             res_rbit;
  cmd_t             res_cmd;
  logic [BP_W-1:0]  k_inc;
  logic             done_loop;
  logic [15:0]      pair;
  logic [7:0]       slid, merged;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign res_cmd   = (state_r == BK_IDLE) ? q_cmd : cmd_r;
  assign k_inc     = k_r + BP_W'(1);
  assign done_loop = (k_inc == cmd_r.byte_end);

  // erase: destination byte k takes source bits from bytes k+shift and k+shift+1
  assign pair = {rd_data_r, lo_r};
  assign slid = 8'(pair >> cmd_r.shift_bits);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (k_r == cmd_r.byte_lo && 3'(j) < cmd_r.bit_sel) begin
        merged[j] = orig_r[j];                       // below the erased run
      end else if ({k_r, 3'(j)} >= (BP_W+3)'(cmd_r.len_after)) begin
        merged[j] = 1'b0;                            // vacated top bits
      end else begin
        merged[j] = slid[j];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            CK_NONE:  state_nxt = BK_IDLE;
            CK_SET:   state_nxt = BK_SET;
            CK_READ:  state_nxt = BK_READ;
            CK_FILL:  state_nxt = BK_FILL;
            CK_ERASE: state_nxt = BK_ER_ORIG;
            default:  state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_SET, BK_READ: begin
        state_nxt = out_free ? BK_IDLE : BK_RESP;
      end
      BK_FILL, BK_ER_RUN: begin
        if (done_loop) state_nxt = out_free ? BK_IDLE : BK_RESP;
      end
      BK_ER_ORIG: state_nxt = BK_ER_LO;
      BK_ER_LO:   state_nxt = BK_ER_RUN;
      BK_RESP: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    logic [7:0] set_byte;
    set_byte = rd_data_r;
    set_byte[cmd_r.bit_sel] = cmd_r.bit_value;

    q_pop    = 1'b0;
    load_out = 1'b0;
    res_rbit = rbit_r;
    rd_en    = 1'b0;
    rd_addr  = AddrW'(src_r);
    wr_en    = 1'b0;
    wr_addr  = AddrW'(k_r);
    wr_data  = 8'h00;
    cmd_nxt  = cmd_r;
    k_nxt    = k_r;
    src_nxt  = src_r;
    lo_nxt   = lo_r;
    orig_nxt = orig_r;
    rbit_nxt = rbit_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_cmd.kind == CK_NONE) begin
            if (out_free) begin
              q_pop    = 1'b1;
              load_out = 1'b1;
              res_rbit = 1'b0;
            end
          end else begin
            q_pop    = 1'b1;
            cmd_nxt  = q_cmd;
            k_nxt    = q_cmd.byte_lo;
            src_nxt  = q_cmd.byte_lo + q_cmd.shift_bytes;
            rbit_nxt = 1'b0;
            rd_en    = 1'b1;
            rd_addr  = AddrW'(q_cmd.byte_lo);
          end
        end
      end
      BK_SET: begin
        wr_en    = 1'b1;
        wr_data  = set_byte;
        load_out = out_free;
      end
      BK_READ: begin
        res_rbit = rd_data_r[cmd_r.bit_sel];
        rbit_nxt = res_rbit;
        load_out = out_free;
      end
      BK_FILL: begin
        wr_en    = 1'b1;
        wr_data  = {8{cmd_r.bit_value}};
        k_nxt    = k_inc;
        load_out = done_loop && out_free;
      end
      BK_ER_ORIG: begin
        orig_nxt = rd_data_r;
        rd_en    = 1'b1;
        src_nxt  = src_r + BP_W'(1);
      end
      BK_ER_LO: begin
        lo_nxt  = rd_data_r;
        rd_en   = 1'b1;
        src_nxt = src_r + BP_W'(1);
      end
      BK_ER_RUN: begin
        wr_en    = 1'b1;
        wr_data  = merged;
        lo_nxt   = rd_data_r;
        rd_en    = 1'b1;
        src_nxt  = src_r + BP_W'(1);
        k_nxt    = k_inc;
        load_out = done_loop && out_free;
      end
      BK_RESP: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    k_r    <= k_nxt;
    src_r  <= src_nxt;
    lo_r   <= lo_nxt;
    orig_r <= orig_nxt;
    rbit_r <= rbit_nxt;
    if (load_out) begin
      out_data_r.read_bit       <= res_rbit;
      out_data_r.status         <= res_cmd.status;
      out_data_r.current_length <= res_cmd.len_after;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

endmodule

/* design/bvre_checker.sv */
// ----------------------------------------------------------------------------
// bvre_checker
// Port-level checks on the result channel of the bit array.
// ----------------------------------------------------------------------------
`include "bit_vector_with_range_erase_assert.svh"

module bvre_checker #(
  parameter int MAX_BITS = 1024
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input bvre_pkg::out_item_t out_data
);
  import bvre_pkg::*;

  `BVRE_ASSERT_IMPLY(a_len_cap, clk, rst_n, out_valid, int'(out_data.current_length) <= MAX_BITS, "length above capacity")
  `BVRE_ASSERT_IMPLY(a_rbit_ok, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.read_bit == 1'b0, "read bit set on failed transaction")
  `BVRE_ASSERT_IMPLY(a_sat_len, clk, rst_n, out_valid && out_data.status == ST_SAT, int'(out_data.current_length) == MAX_BITS, "saturated resize not at capacity")
  `BVRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind bit_vector_with_range_erase bvre_checker #(.MAX_BITS(MAX_BITS)) u_checker (.*);
